>>> hdl/ter_pkg.sv
// ----------------------------------------------------------------------------
// ter_pkg
// Shared types and constants of the triangle edge rasteriser.
// ----------------------------------------------------------------------------
package ter_pkg;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_CULL   = 2'd1,
    KIND_PIXEL  = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [1:0] REG_COLOR_A = 2'd0;
  localparam logic [1:0] REG_COLOR_B = 2'd1;
  localparam logic [1:0] REG_COLOR_C = 2'd2;

  // result of one request as it leaves the back end
  typedef struct packed {
    kind_t       kind;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic        covered;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

>>> hdl/triangle_edge_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer
// Edge-function triangle rasteriser with top-left fill and colour blend.
// ----------------------------------------------------------------------------
// flow: one request at a time; the next is not started until the result of
//   the last one has been taken. A load, an idle step or an uncovered pixel
//   goes from setup straight to output; a covered pixel first blends each
//   colour channel, dividing by the area in the bit-serial divider
// reset: synchronous, clears control state, colours return to red, green, blue
module triangle_edge_rasterizer #(
  parameter int COORD_BITS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y, pad
  input  logic [71:0] s_axis_tdata,
  // cmd
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x, pixel_y, covered, red, green, blue, pad
  output logic [47:0] m_axis_tdata,
  // kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  logic [23:0]      color_a, color_b, color_c;
  logic             f_valid, f_ready, b_valid, b_ready;
  logic [66:0]      f_data, b_data;
  ter_pkg::result_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      color_a <= 24'hFF0000;
      color_b <= 24'h00FF00;
      color_c <= 24'h0000FF;
    end else if (cfg_valid) begin
      case (cfg_index)
        ter_pkg::REG_COLOR_A: color_a <= cfg_data;
        ter_pkg::REG_COLOR_B: color_b <= cfg_data;
        ter_pkg::REG_COLOR_C: color_c <= cfg_data;
        default: ;
      endcase
    end
  end

  ter_front #(.COORD_BITS(COORD_BITS)) u_front (
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .s_data({s_axis_tdata[65:0], s_axis_tuser}),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  ter_queue #(.WIDTH(67), .DEPTH(2)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  ter_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .color_a(color_a), .color_b(color_b), .color_c(color_c),
    .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_data(res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {1'b0, res.blue, res.green, res.red, res.covered,
                         res.pixel_y, res.pixel_x};
endmodule

>>> hdl/ter_queue.sv
// ----------------------------------------------------------------------------
// ter_queue
// Small request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ter_queue #(
  parameter int WIDTH = 67,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(DEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with unequal pointers");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("push not counted");
endmodule

>>> hdl/ter_front.sv
// ----------------------------------------------------------------------------
// ter_front
// Accepts requests, masks coordinates and classifies each as load or step.
// ----------------------------------------------------------------------------
module ter_front #(
  parameter int COORD_BITS = 11
) (
  input  logic        s_valid,
  output logic        s_ready,
  input  logic [66:0] s_data,
  output logic        q_valid,
  input  logic        q_ready,
  output logic [66:0] q_data
);
  localparam logic [10:0] CMASK = 11'((1 << COORD_BITS) - 1);

  logic [10:0] crd [6];
  logic        is_step;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      crd[i] = s_data[1 + 11*i +: 11] & CMASK;
    end
    is_step = (s_data[0] == ter_pkg::CMD_STEP);
  end

  // a step carries no coordinates onward
  assign q_data  = is_step ? {66'd0, ter_pkg::CMD_STEP}
                           : {crd[5], crd[4], crd[3], crd[2], crd[1], crd[0],
                              ter_pkg::CMD_LOAD};
  assign q_valid = s_valid;
  assign s_ready = q_ready;
endmodule

>>> hdl/ter_back.sv
// ----------------------------------------------------------------------------
// ter_back
// Triangle setup, edge stepping, colour blend with a restoring divider.
// ----------------------------------------------------------------------------
module ter_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [66:0]         q_data,
  input  logic [23:0]         color_a,
  input  logic [23:0]         color_b,
  input  logic [23:0]         color_c,
  output logic                r_valid,
  input  logic                r_ready,
  output ter_pkg::result_t    r_data
);
  ter_pkg::back_state_t state, state_next;

  logic               active;
  logic [10:0]        box_x_min, box_x_max, box_y_max, cursor_x, cursor_y;
  logic signed [31:0] edge_now [3];
  logic signed [31:0] edge_row [3];
  logic signed [12:0] step_col [3];
  logic signed [12:0] step_row [3];
  logic [23:0]        area;

  logic signed [12:0] ax, ay, bx, by, cx, cy;
  logic [10:0]        x0, y0;
  logic signed [31:0] area_w;

  // blend datapath
  logic [1:0]         ch;
  logic [1:0]         term;
  logic signed [35:0] num;
  logic [35:0]        rem;
  logic [35:0]        quo;
  logic [5:0]         bitn;
  logic [7:0]         chan [3];
  logic               cov;
  logic               fin;
  ter_pkg::result_t   res;
  ter_pkg::result_t   res_next;
  logic               res_valid;

  assign ax = 13'(q_data[11:1]);  assign ay = 13'(q_data[22:12]);
  assign bx = 13'(q_data[33:23]); assign by = 13'(q_data[44:34]);
  assign cx = 13'(q_data[55:45]); assign cy = 13'(q_data[66:56]);

  function automatic logic [10:0] min3(input logic [10:0] a, b, c);
    logic [10:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [10:0] max3(input logic [10:0] a, b, c);
    logic [10:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [31:0] efn(input logic signed [12:0] pax, pay,
                                             pbx, pby, ppx, ppy);
    return 32'((pbx - pax) * (ppy - pay)) - 32'((pby - pay) * (ppx - pax));
  endfunction

  function automatic logic signed [31:0] bias(input logic signed [12:0] sx, sy,
                                              ex, ey);
    logic signed [12:0] dx, dy;
    dx = ex - sx;
    dy = ey - sy;
    return ((dy == 0 && dx > 0) || dy < 0) ? 32'sd0 : -32'sd1;
  endfunction

  assign x0     = min3(q_data[11:1], q_data[33:23], q_data[55:45]);
  assign y0     = min3(q_data[22:12], q_data[44:34], q_data[66:56]);
  assign area_w = efn(ax, ay, bx, by, cx, cy);

  assign cov = !edge_now[0][31] && !edge_now[1][31] && !edge_now[2][31];
  assign fin = (cursor_x >= box_x_max) && (cursor_y >= box_y_max);

  // colour byte of the current channel and term
  logic [7:0]         cbyte;
  logic signed [31:0] wsel;
  logic [23:0]        csel;
  always_comb begin
    case (term)
      2'd0:    begin csel = color_a; wsel = edge_now[0]; end
      2'd1:    begin csel = color_b; wsel = edge_now[1]; end
      default: begin csel = color_c; wsel = edge_now[2]; end
    endcase
    case (ch)
      2'd0:    cbyte = csel[23:16];
      2'd1:    cbyte = csel[15:8];
      default: cbyte = csel[7:0];
    endcase
  end

  // one restoring step of the divider, numerator loaded on the first step
  logic [35:0] div_q;
  logic [35:0] div_r;
  logic [35:0] div_sh;
  logic        div_bit;
  logic [35:0] div_quo_next;
  always_comb begin
    div_q        = (bitn == 6'd0) ? ((num < 0) ? 36'd0 : 36'(num)) : quo;
    div_r        = (bitn == 6'd0) ? 36'd0 : rem;
    div_sh       = {div_r[34:0], div_q[35]};
    div_bit      = (div_sh >= {12'd0, area});
    div_quo_next = {div_q[34:0], div_bit};
  end

  // result of the request at the head of the queue
  always_comb begin
    res_next = '0;
    if (q_data[0] == ter_pkg::CMD_LOAD) begin
      res_next.kind = (area_w < 1) ? ter_pkg::KIND_CULL : ter_pkg::KIND_ACCEPT;
    end else if (!active) begin
      res_next.kind = ter_pkg::KIND_IDLE;
    end else begin
      res_next.kind    = ter_pkg::KIND_PIXEL;
      res_next.pixel_x = cursor_x;
      res_next.pixel_y = cursor_y;
      res_next.covered = cov;
      res_next.red     = cov ? chan[0] : 8'd0;
      res_next.green   = cov ? chan[1] : 8'd0;
      res_next.blue    = cov ? chan[2] : 8'd0;
      res_next.last    = fin;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ter_pkg::ST_IDLE:  if (q_valid && !res_valid) state_next = ter_pkg::ST_SETUP;
      ter_pkg::ST_SETUP: state_next = (q_data[0] == ter_pkg::CMD_STEP && active && cov)
                                      ? ter_pkg::ST_MUL : ter_pkg::ST_OUT;
      ter_pkg::ST_MUL:   if (term == 2'd2) state_next = ter_pkg::ST_DIV;
      ter_pkg::ST_DIV:   if (bitn == 6'd35) state_next = (ch == 2'd2) ? ter_pkg::ST_OUT
                                                                     : ter_pkg::ST_MUL;
      ter_pkg::ST_OUT:   state_next = ter_pkg::ST_IDLE;
      default:           state_next = ter_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == ter_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ter_pkg::ST_IDLE;
      active    <= 1'b0;
      res_valid <= 1'b0;
      box_x_min <= '0; box_x_max <= '0; box_y_max <= '0;
      cursor_x  <= '0; cursor_y  <= '0;
      area      <= '0;
      for (int i = 0; i < 3; i++) begin
        edge_now[i] <= '0; edge_row[i] <= '0; step_col[i] <= '0; step_row[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ter_pkg::ST_OUT) res_valid <= 1'b1;
      else if (res_valid && r_ready) res_valid <= 1'b0;
      case (state)
        ter_pkg::ST_SETUP: begin
          ch   <= 2'd0;
          term <= 2'd0;
          num  <= '0;
          for (int i = 0; i < 3; i++) chan[i] <= '0;
        end
        ter_pkg::ST_MUL: begin
          num  <= num + 36'(wsel * $signed({1'b0, cbyte}));
          term <= term + 2'd1;
          if (term == 2'd2) begin
            rem  <= '0;
            bitn <= '0;
          end
        end
        ter_pkg::ST_DIV: begin
          // one quotient bit a cycle
          rem  <= div_bit ? (div_sh - {12'd0, area}) : div_sh;
          quo  <= div_quo_next;
          bitn <= bitn + 6'd1;
          if (bitn == 6'd35) begin
            // store finished channel, saturated
            chan[ch] <= (div_quo_next > 36'd255) ? 8'hFF : div_quo_next[7:0];
            ch   <= ch + 2'd1;
            term <= 2'd0;
            num  <= '0;
          end
        end
        ter_pkg::ST_OUT: begin
          res <= res_next;
          if (q_data[0] == ter_pkg::CMD_LOAD) begin
            if (area_w < 1) begin
              active   <= 1'b0;
            end else begin
              active    <= 1'b1;
              area      <= area_w[23:0];
              box_x_min <= x0;
              box_x_max <= max3(q_data[11:1], q_data[33:23], q_data[55:45]);
              box_y_max <= max3(q_data[22:12], q_data[44:34], q_data[66:56]);
              cursor_x  <= x0;
              cursor_y  <= y0;
              step_col[0] <= by - cy; step_col[1] <= cy - ay; step_col[2] <= ay - by;
              step_row[0] <= cx - bx; step_row[1] <= ax - cx; step_row[2] <= bx - ax;
              edge_row[0] <= efn(bx, by, cx, cy, 13'(x0), 13'(y0)) + bias(bx, by, cx, cy);
              edge_row[1] <= efn(cx, cy, ax, ay, 13'(x0), 13'(y0)) + bias(cx, cy, ax, ay);
              edge_row[2] <= efn(ax, ay, bx, by, 13'(x0), 13'(y0)) + bias(ax, ay, bx, by);
              edge_now[0] <= efn(bx, by, cx, cy, 13'(x0), 13'(y0)) + bias(bx, by, cx, cy);
              edge_now[1] <= efn(cx, cy, ax, ay, 13'(x0), 13'(y0)) + bias(cx, cy, ax, ay);
              edge_now[2] <= efn(ax, ay, bx, by, 13'(x0), 13'(y0)) + bias(ax, ay, bx, by);
            end
          end else if (active) begin
            if (fin) begin
              active <= 1'b0;
            end else if (cursor_x < box_x_max) begin
              cursor_x <= cursor_x + 11'd1;
              for (int i = 0; i < 3; i++) edge_now[i] <= edge_now[i] + 32'(step_col[i]);
            end else begin
              cursor_x <= box_x_min;
              cursor_y <= cursor_y + 11'd1;
              for (int i = 0; i < 3; i++) begin
                edge_row[i] <= edge_row[i] + 32'(step_row[i]);
                edge_now[i] <= edge_row[i] + 32'(step_row[i]);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign r_valid = res_valid;
  assign r_data  = res;

  assert property (@(posedge clk) disable iff (rst)
    (state == ter_pkg::ST_OUT) |=> r_valid)
    else $error("result not raised");
  assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_data.kind != ter_pkg::KIND_PIXEL) |-> (r_data.last == 1'b0))
    else $error("last outside pixel result");
  assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_data.covered) |-> (r_data.red == 8'd0))
    else $error("colour on uncovered pixel");
endmodule
